>>> src/blr_pkg.sv
// ----------------------------------------------------------------------------
// blr_pkg: shared constants for the line rasterizer
// Field widths, register indexes, reset values and item mode codes.
// ----------------------------------------------------------------------------
package blr_pkg;

  // Default coordinate width. Columns and rows each use this many bits.
  localparam int COORD_BITS_DEF = 11;

  // Fixed widths of the configuration registers and result fields.
  localparam int STRIDE_W = 12;
  localparam int COLOR_W  = 32;
  localparam int OFFSET_W = 24;

  // Bytes written per pixel. This scales the byte offset.
  localparam int BYTES_PER_PIXEL = 4;

  // Configuration port.
  localparam int CFG_INDEX_W = 1;
  localparam logic [CFG_INDEX_W-1:0] REG_LINE_STRIDE = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_DRAW_COLOR  = 1'd1;

  // Register values after reset.
  localparam logic [STRIDE_W-1:0] STRIDE_RESET = 12'd800;
  localparam logic [COLOR_W-1:0]  COLOR_RESET  = 32'hFFFF_FFFF;

  // Input item modes.
  localparam logic MODE_START = 1'b0;
  localparam logic MODE_STEP  = 1'b1;

endpackage

>>> src/blr_stepper.sv
// ----------------------------------------------------------------------------
// blr_stepper: Bresenham line state and stepping logic
// Holds the current line and computes the pixel of each accepted request.
// ----------------------------------------------------------------------------
module blr_stepper #(
  parameter int COORD_BITS = blr_pkg::COORD_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  accept,
  input  logic                  mode,
  input  logic [COORD_BITS-1:0] x_start,
  input  logic [COORD_BITS-1:0] y_start,
  input  logic [COORD_BITS-1:0] x_end,
  input  logic [COORD_BITS-1:0] y_end,
  output logic                  pix_valid,
  output logic [COORD_BITS-1:0] pix_x,
  output logic [COORD_BITS-1:0] pix_y,
  output logic                  pix_last
);

  localparam int DW = COORD_BITS + 1;
  localparam int EW = COORD_BITS + 3;

  // Line state.
  logic                  active, active_next;
  logic [COORD_BITS-1:0] cur_x, cur_x_next;
  logic [COORD_BITS-1:0] cur_y, cur_y_next;
  logic [COORD_BITS-1:0] target_x, target_x_next;
  logic [COORD_BITS-1:0] target_y, target_y_next;
  logic [DW-1:0]         delta_x, delta_x_next;
  logic [DW-1:0]         delta_y_abs, delta_y_abs_next;
  logic signed [EW-1:0]  error_term, error_term_next;
  logic                  step_down, step_down_next;
  logic                  steep, steep_next;

  // Endpoint ordering for a start request: x never decreases, and a
  // vertical line runs with y never decreasing.
  logic                  swap;
  logic [COORD_BITS-1:0] xa, ya, xb, yb;
  logic                  new_down;
  logic [DW-1:0]         new_dx, new_dy;
  logic                  new_steep;
  logic signed [EW-1:0]  new_err;

  assign swap = (x_end < x_start) || ((x_end == x_start) && (y_end < y_start));
  assign xa   = swap ? x_end   : x_start;
  assign ya   = swap ? y_end   : y_start;
  assign xb   = swap ? x_start : x_end;
  assign yb   = swap ? y_start : y_end;

  assign new_down  = yb < ya;
  assign new_dx    = {1'b0, xb - xa};
  assign new_dy    = new_down ? {1'b0, ya - yb} : {1'b0, yb - ya};
  assign new_steep = new_dy > new_dx;
  assign new_err   = new_steep ?
      ($signed({1'b0, new_dx, 1'b0}) - $signed({2'b00, new_dy})) :
      ($signed({1'b0, new_dy, 1'b0}) - $signed({2'b00, new_dx}));

  // Step of an active line: the major axis always moves, the minor axis
  // moves when the error term is not negative.
  logic                  err_nonneg;
  logic [COORD_BITS-1:0] y_moved;
  logic [COORD_BITS-1:0] x_moved;
  logic signed [EW-1:0]  two_dx, two_dy;
  logic [COORD_BITS-1:0] step_x, step_y;
  logic signed [EW-1:0]  step_err;

  assign err_nonneg = !error_term[EW-1];
  assign y_moved    = step_down ? cur_y - COORD_BITS'(1) : cur_y + COORD_BITS'(1);
  assign x_moved    = cur_x + COORD_BITS'(1);
  assign two_dx     = $signed({1'b0, delta_x, 1'b0});
  assign two_dy     = $signed({1'b0, delta_y_abs, 1'b0});

  always_comb begin
    if (steep) begin
      step_y = y_moved;
      if (err_nonneg) begin
        step_x   = x_moved;
        step_err = error_term + two_dx - two_dy;
      end else begin
        step_x   = cur_x;
        step_err = error_term + two_dx;
      end
    end else begin
      step_x = x_moved;
      if (err_nonneg) begin
        step_y   = y_moved;
        step_err = error_term + two_dy - two_dx;
      end else begin
        step_y   = cur_y;
        step_err = error_term + two_dy;
      end
    end
  end

  // Next state and the pixel that this request emits.
  always_comb begin
    active_next      = active;
    cur_x_next       = cur_x;
    cur_y_next       = cur_y;
    target_x_next    = target_x;
    target_y_next    = target_y;
    delta_x_next     = delta_x;
    delta_y_abs_next = delta_y_abs;
    error_term_next  = error_term;
    step_down_next   = step_down;
    steep_next       = steep;
    pix_valid        = 1'b0;
    pix_x            = '0;
    pix_y            = '0;
    pix_last         = 1'b0;
    if (mode == blr_pkg::MODE_START) begin
      cur_x_next       = xa;
      cur_y_next       = ya;
      target_x_next    = xb;
      target_y_next    = yb;
      delta_x_next     = new_dx;
      delta_y_abs_next = new_dy;
      error_term_next  = new_err;
      step_down_next   = new_down;
      steep_next       = new_steep;
      pix_valid        = 1'b1;
      pix_x            = xa;
      pix_y            = ya;
      pix_last         = (xa == xb) && (ya == yb);
      active_next      = !pix_last;
    end else if (active) begin
      cur_x_next      = step_x;
      cur_y_next      = step_y;
      error_term_next = step_err;
      pix_valid       = 1'b1;
      pix_x           = step_x;
      pix_y           = step_y;
      pix_last        = (step_x == target_x) && (step_y == target_y);
      active_next     = !pix_last;
    end
  end

  // State update on every accepted request.
  always_ff @(posedge clk) begin
    if (rst) begin
      active      <= 1'b0;
      cur_x       <= '0;
      cur_y       <= '0;
      target_x    <= '0;
      target_y    <= '0;
      delta_x     <= '0;
      delta_y_abs <= '0;
      error_term  <= '0;
      step_down   <= 1'b0;
      steep       <= 1'b0;
    end else if (accept) begin
      active      <= active_next;
      cur_x       <= cur_x_next;
      cur_y       <= cur_y_next;
      target_x    <= target_x_next;
      target_y    <= target_y_next;
      delta_x     <= delta_x_next;
      delta_y_abs <= delta_y_abs_next;
      error_term  <= error_term_next;
      step_down   <= step_down_next;
      steep       <= steep_next;
    end
  end

endmodule

>>> src/blr_addr.sv
// ----------------------------------------------------------------------------
// blr_addr: byte offset unit and result register
// Forms the framebuffer byte offset of a pixel and holds the result.
// ----------------------------------------------------------------------------
module blr_addr #(
  parameter int COORD_BITS = blr_pkg::COORD_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          load,
  input  logic                          load_valid,
  input  logic                          pix_valid,
  input  logic [COORD_BITS-1:0]         pix_x,
  input  logic [COORD_BITS-1:0]         pix_y,
  input  logic                          pix_last,
  input  logic [blr_pkg::STRIDE_W-1:0]  line_stride,
  input  logic [blr_pkg::COLOR_W-1:0]   draw_color,
  output logic                          out_valid,
  output logic                          pixel_valid,
  output logic [COORD_BITS-1:0]         pixel_x,
  output logic [COORD_BITS-1:0]         pixel_y,
  output logic [blr_pkg::OFFSET_W-1:0]  pixel_offset,
  output logic [blr_pkg::COLOR_W-1:0]   pixel_color,
  output logic                          last_pixel
);

  localparam int NeedW = COORD_BITS + blr_pkg::STRIDE_W + 4;
  localparam int WideW = (NeedW > blr_pkg::OFFSET_W) ? NeedW : blr_pkg::OFFSET_W;

  // Offset = bytes per pixel * (x + y * stride), kept modulo the field width.
  logic [WideW-1:0]             pix_index;
  logic [WideW-1:0]             byte_offset;
  logic [blr_pkg::OFFSET_W-1:0] offset_calc;

  assign pix_index   = WideW'(pix_x) + WideW'(pix_y) * WideW'(line_stride);
  assign byte_offset = pix_index * WideW'(blr_pkg::BYTES_PER_PIXEL);
  assign offset_calc = byte_offset[blr_pkg::OFFSET_W-1:0];

  // Result valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= load_valid;
    end
  end

  // Result payload. A step with no active line gives all fields zero.
  always_ff @(posedge clk) begin
    if (load) begin
      pixel_valid  <= pix_valid;
      pixel_x      <= pix_valid ? pix_x : '0;
      pixel_y      <= pix_valid ? pix_y : '0;
      pixel_offset <= pix_valid ? offset_calc : '0;
      pixel_color  <= pix_valid ? draw_color : '0;
      last_pixel   <= pix_valid & pix_last;
    end
  end

endmodule

>>> src/bresenham_line_rasterizer_top.sv
// ----------------------------------------------------------------------------
// bresenham_line_rasterizer_top: Bresenham line rasterizer
// Start and step requests in, one pixel result out for every request.
// ----------------------------------------------------------------------------
// The rasterizer takes one request per clock when not stalled and returns
// exactly one result per request, via the pixel stage and result registers.
// A start request (mode 0) loads two endpoints and returns the first pixel;
// each step request (mode 1) returns the next pixel, with last_pixel set on
// the final one. A step with no line in progress returns a result with
// pixel_valid low and all other fields zero. The line state is updated in
// the accept cycle, so throughput is one request per clock unless stalled,
// set by the stepping adder/compare path; the next stage holds the single
// stride multiplier for the byte offset. Configuration writes are always
// ready and should be made only while no results are pending.
module bresenham_line_rasterizer_top #(
  parameter int COORD_BITS = blr_pkg::COORD_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  // Request channel
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            mode,
  input  logic [COORD_BITS-1:0]           x_start,
  input  logic [COORD_BITS-1:0]           y_start,
  input  logic [COORD_BITS-1:0]           x_end,
  input  logic [COORD_BITS-1:0]           y_end,
  // Result channel
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            pixel_valid,
  output logic [COORD_BITS-1:0]           pixel_x,
  output logic [COORD_BITS-1:0]           pixel_y,
  output logic [blr_pkg::OFFSET_W-1:0]    pixel_offset,
  output logic [blr_pkg::COLOR_W-1:0]     pixel_color,
  output logic                            last_pixel,
  // Configuration write channel
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [blr_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [blr_pkg::COLOR_W-1:0]     cfg_data
);

  // Configuration registers.
  logic [blr_pkg::STRIDE_W-1:0] line_stride;
  logic [blr_pkg::COLOR_W-1:0]  draw_color;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      line_stride <= blr_pkg::STRIDE_RESET;
      draw_color  <= blr_pkg::COLOR_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        blr_pkg::REG_LINE_STRIDE: line_stride <= cfg_data[blr_pkg::STRIDE_W-1:0];
        blr_pkg::REG_DRAW_COLOR:  draw_color  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Pipeline flow control: the result register advances when empty or
  // taken, and the pixel stage advances into it.
  logic out_advance;
  logic s1_ready;
  logic accept;

  logic                  s1_valid;
  logic                  s1_pix_valid;
  logic [COORD_BITS-1:0] s1_x;
  logic [COORD_BITS-1:0] s1_y;
  logic                  s1_last;

  assign out_advance = !out_valid || !out_stall;
  assign s1_ready    = !s1_valid || out_advance;
  assign in_stall    = !s1_ready;
  assign accept      = in_valid && s1_ready;

  // Line stepping.
  logic                  pix_valid;
  logic [COORD_BITS-1:0] pix_x;
  logic [COORD_BITS-1:0] pix_y;
  logic                  pix_last;

  blr_stepper #(
    .COORD_BITS(COORD_BITS)
  ) u_stepper (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .mode     (mode),
    .x_start  (x_start),
    .y_start  (y_start),
    .x_end    (x_end),
    .y_end    (y_end),
    .pix_valid(pix_valid),
    .pix_x    (pix_x),
    .pix_y    (pix_y),
    .pix_last (pix_last)
  );

  // Pixel stage register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_ready) begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pix_valid <= pix_valid;
      s1_x         <= pix_x;
      s1_y         <= pix_y;
      s1_last      <= pix_last;
    end
  end

  // Offset computation and result register.
  blr_addr #(
    .COORD_BITS(COORD_BITS)
  ) u_addr (
    .clk         (clk),
    .rst         (rst),
    .load        (out_advance),
    .load_valid  (s1_valid),
    .pix_valid   (s1_pix_valid),
    .pix_x       (s1_x),
    .pix_y       (s1_y),
    .pix_last    (s1_last),
    .line_stride (line_stride),
    .draw_color  (draw_color),
    .out_valid   (out_valid),
    .pixel_valid (pixel_valid),
    .pixel_x     (pixel_x),
    .pixel_y     (pixel_y),
    .pixel_offset(pixel_offset),
    .pixel_color (pixel_color),
    .last_pixel  (last_pixel)
  );

endmodule
